FILE: hw/rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for clocked concurrent assertions.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising edge outside reset.
`define DQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Implication form: when cond holds, prop must hold in the next cycle.
`define DQ_ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error(msg);

`endif

FILE: hw/rtl/dq_pkg.sv
// ---------------------------------------------------------------------------
// dq_pkg
// Types and codes shared by the deque core and its channel interfaces.
// ---------------------------------------------------------------------------
package dq_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned FUNC_W = 3;
  localparam int unsigned OCC_W  = 7;
  localparam int unsigned STAT_W = 2;

  // Operation codes
  localparam logic [FUNC_W-1:0] FUNC_PUSH_FRONT = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_PUSH_BACK  = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_POP_FRONT  = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_POP_BACK   = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR      = 3'd4;
  localparam logic [FUNC_W-1:0] FUNC_QUERY      = 3'd5;

  // Status codes
  localparam logic [STAT_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STATUS_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] STATUS_EMPTY = 2'd2;

  localparam logic signed [DATA_W-1:0] EMPTY_VALUE = -32'sd1;

  typedef struct packed {
    logic [FUNC_W-1:0]        func;
    logic signed [DATA_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] front_value;
    logic signed [DATA_W-1:0] back_value;
    logic [OCC_W-1:0]         occupancy;
    logic                     is_empty;
    logic [STAT_W-1:0]        status;
  } rsp_t;

endpackage

FILE: hw/rtl/dq_if.sv
// ---------------------------------------------------------------------------
// dq_if
// Valid/ready channels for deque requests and responses.
// ---------------------------------------------------------------------------
interface dq_req_if;
  logic          valid;
  logic          ready;
  dq_pkg::req_t  payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface dq_rsp_if;
  logic          valid;
  logic          ready;
  dq_pkg::rsp_t  payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

FILE: hw/rtl/double_ended_queue_core.sv
// ---------------------------------------------------------------------------
// double_ended_queue_core
// Double-ended queue of signed 32-bit words in a DEPTH-entry ring memory.
// ---------------------------------------------------------------------------
// Usage:
//   req carries one operation per transaction: push front/back, pop
//   front/back, clear or query (unused codes behave as a query). rsp returns
//   exactly one transaction per request: front and back words (-1 when the
//   queue is empty), the occupancy masked to 7 bits, an empty flag and a
//   status (push rejected when full, pop rejected when empty).
// Timing:
//   Accept cycle: pointers and count update and a push is written to the
//   ring memory. Next cycle: both ends are read through two read ports.
//   Then the response register is loaded once it is free, and rsp.valid
//   rises. A new request is not taken until the sequencer is back in idle;
//   req.ready is high only while idle.
// Reset:
//   Synchronous, active high. Clears the front index, the count, the
//   sequencer and the response valid; req.ready stays low throughout. The
//   memory is not cleared; only entries written by a push reach the response.
// Back-pressure:
//   A response waiting in the output register does not block acceptance of
//   the next request; the sequencer holds in its final cycle until the
//   output register is free.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module double_ended_queue_core #(
  parameter int unsigned DEPTH = 64
) (
  input  logic           clk,
  input  logic           rst,
  dq_req_if.sink         req,
  dq_rsp_if.source       rsp
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned SW = AW + 1;   // sum width, holds up to 2*DEPTH-1

  localparam logic [AW-1:0] LAST_IDX  = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);
  localparam logic [SW-1:0] DEPTH_SUM = SW'(DEPTH);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_READ = 3'b010,
    S_LOAD = 3'b100
  } state_t;

  // Reduce a sum below 2*DEPTH into a ring index.
  function automatic logic [AW-1:0] ring_wrap(input logic [SW-1:0] sum);
    logic [SW-1:0] red;
    red = (sum >= DEPTH_SUM) ? (sum - DEPTH_SUM) : sum;
    return red[AW-1:0];
  endfunction

  // Ring memory
  logic signed [dq_pkg::DATA_W-1:0] mem [DEPTH];

  state_t                      state;
  logic [AW-1:0]               front_index;
  logic [AW-1:0]               front_index_next;
  logic [CW-1:0]               entry_count;
  logic [CW-1:0]               entry_count_next;
  logic [dq_pkg::STAT_W-1:0]   status;
  logic [dq_pkg::STAT_W-1:0]   status_next;

  logic                        wr_en;
  logic [AW-1:0]               wr_addr;
  logic [AW-1:0]               back_addr;
  logic [AW-1:0]               tail_addr;

  logic signed [dq_pkg::DATA_W-1:0] rd_front;
  logic signed [dq_pkg::DATA_W-1:0] rd_back;

  logic                        rsp_valid;
  dq_pkg::rsp_t                rsp_data;

  logic                        accept;
  logic                        is_full;
  logic                        is_none;
  logic                        load;

  assign accept  = req.valid && req.ready;
  assign is_full = (entry_count == FULL_CNT);
  assign is_none = (entry_count == '0);
  assign load    = (state == S_LOAD) && (!rsp_valid || rsp.ready);

  // Slot after the back entry, used by push back (count < DEPTH there)
  assign tail_addr = ring_wrap({1'b0, front_index} + SW'(entry_count));
  // Back entry; meaningless when empty, masked at the output
  assign back_addr = ring_wrap({1'b0, front_index} + SW'(entry_count) - SW'(1));

  // Operation decode
  always_comb begin
    front_index_next = front_index;
    entry_count_next = entry_count;
    status_next      = dq_pkg::STATUS_OK;
    wr_en            = 1'b0;
    wr_addr          = tail_addr;
    case (req.payload.func)
      dq_pkg::FUNC_PUSH_FRONT: begin
        if (is_full) begin
          status_next = dq_pkg::STATUS_FULL;
        end else begin
          front_index_next = (front_index == '0) ? LAST_IDX : front_index - AW'(1);
          wr_addr          = front_index_next;
          wr_en            = 1'b1;
          entry_count_next = entry_count + CW'(1);
        end
      end
      dq_pkg::FUNC_PUSH_BACK: begin
        if (is_full) begin
          status_next = dq_pkg::STATUS_FULL;
        end else begin
          wr_en            = 1'b1;
          entry_count_next = entry_count + CW'(1);
        end
      end
      dq_pkg::FUNC_POP_FRONT: begin
        if (is_none) begin
          status_next = dq_pkg::STATUS_EMPTY;
        end else begin
          front_index_next = (front_index == LAST_IDX) ? '0 : front_index + AW'(1);
          entry_count_next = entry_count - CW'(1);
        end
      end
      dq_pkg::FUNC_POP_BACK: begin
        if (is_none) begin
          status_next = dq_pkg::STATUS_EMPTY;
        end else begin
          entry_count_next = entry_count - CW'(1);
        end
      end
      dq_pkg::FUNC_CLEAR: begin
        front_index_next = '0;
        entry_count_next = '0;
      end
      default: begin
        // query and unused codes leave the queue as it is
      end
    endcase
  end

  // Write port: a push lands in the accept cycle, before the reads in S_READ
  always_ff @(posedge clk) begin
    if (accept && wr_en) begin
      mem[wr_addr] <= req.payload.value;
    end
  end

  // Two registered read ports, addressed from the updated pointers
  always_ff @(posedge clk) begin
    if (state == S_READ) begin
      rd_front <= mem[front_index];
      rd_back  <= mem[back_addr];
    end
  end

  // Sequencer and queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      front_index <= '0;
      entry_count <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            front_index <= front_index_next;
            entry_count <= entry_count_next;
            state       <= S_READ;
          end
        end
        S_READ: begin
          state <= S_LOAD;
        end
        S_LOAD: begin
          if (load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Status is captured with the transaction
  always_ff @(posedge clk) begin
    if (accept) begin
      status <= status_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (load) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rsp_data.front_value <= is_none ? dq_pkg::EMPTY_VALUE : rd_front;
      rsp_data.back_value  <= is_none ? dq_pkg::EMPTY_VALUE : rd_back;
      rsp_data.occupancy   <= dq_pkg::OCC_W'(entry_count);
      rsp_data.is_empty    <= is_none;
      rsp_data.status      <= status;
    end
  end

  assign req.ready   = (state == S_IDLE) && !rst;
  assign rsp.valid   = rsp_valid;
  assign rsp.payload = rsp_data;

  // Checks
  `DQ_ASSERT(a_count_bound, entry_count <= FULL_CNT, "entry count beyond depth")
  `DQ_ASSERT(a_empty_marks,
    !(rsp.valid && rsp.payload.is_empty) ||
      ((rsp.payload.front_value == dq_pkg::EMPTY_VALUE) &&
       (rsp.payload.back_value == dq_pkg::EMPTY_VALUE)),
    "empty response carries data")
  `DQ_ASSERT_NEXT(a_accept_seq, accept, state == S_READ, "accepted request did not start a read")
  `DQ_ASSERT_NEXT(a_full_hold,
    accept && is_full &&
      ((req.payload.func == dq_pkg::FUNC_PUSH_FRONT) ||
       (req.payload.func == dq_pkg::FUNC_PUSH_BACK)),
    $stable(entry_count) && $stable(front_index),
    "rejected push changed the queue")

endmodule
